>>> rtl/pfm_pkg.sv
package pfm_pkg;

    localparam int FRAC_BITS_DEF = 24;

    localparam int POS_W = 31;
    localparam int VEL_W = 40;
    localparam int ACC_W = 64;

    localparam int S_TDATA_W = 208;
    localparam int M_TDATA_W = 272;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;

    localparam int DVD_W = 128;
    localparam int DVS_W = 64;

    localparam logic [CFG_IDX_W-1:0] REG_CUTOFF = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_MINR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMASS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DT     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE   = 3'd4;

    localparam logic [30:0] CUTOFF_RST = 31'd167772;
    localparam logic [30:0] MINR_RST   = 31'd1678;
    localparam logic [31:0] IMASS_RST  = 32'd6553600;
    localparam logic [30:0] DT_RST     = 31'd8389;
    localparam logic [30:0] SIZE_RST   = 31'd16777216;

endpackage

>>> rtl/pfm_divider.sv
module pfm_divider (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           start,
    input  logic [pfm_pkg::DVD_W-1:0]      dividend,
    input  logic [pfm_pkg::DVS_W-1:0]      divisor,
    output logic                           done,
    output logic [pfm_pkg::DVS_W-1:0]      quotient
);

    logic                          busy_reg;
    logic                          done_reg;
    logic [6:0]                    cnt_reg;
    logic [pfm_pkg::DVS_W-1:0]     rem_reg;
    logic [pfm_pkg::DVS_W-1:0]     lo_reg;
    logic [pfm_pkg::DVS_W-1:0]     q_reg;
    logic [pfm_pkg::DVS_W-1:0]     dvs_reg;
    logic [pfm_pkg::DVS_W:0]       rem_sh;
    logic                          take;

    assign rem_sh = {rem_reg, lo_reg[pfm_pkg::DVS_W-1]};
    assign take   = rem_sh >= {1'b0, dvs_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                dvs_reg <= divisor;
                rem_reg <= dividend[pfm_pkg::DVD_W-1:pfm_pkg::DVS_W];
                lo_reg  <= dividend[pfm_pkg::DVS_W-1:0];
                cnt_reg <= '0;
                // quotient would not fit in 64 bits
                if (dividend[pfm_pkg::DVD_W-1:pfm_pkg::DVS_W] >= divisor) begin
                    q_reg    <= '1;
                    done_reg <= 1'b1;
                end else begin
                    q_reg    <= '0;
                    busy_reg <= 1'b1;
                end
            end else if (busy_reg) begin
                lo_reg <= {lo_reg[pfm_pkg::DVS_W-2:0], 1'b0};
                q_reg  <= {q_reg[pfm_pkg::DVS_W-2:0], take};
                if (take) begin
                    rem_reg <= rem_sh[pfm_pkg::DVS_W-1:0] - dvs_reg;
                end else begin
                    rem_reg <= rem_sh[pfm_pkg::DVS_W-1:0];
                end
                cnt_reg <= cnt_reg + 7'd1;
                if (cnt_reg == 7'(pfm_pkg::DVS_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule

>>> rtl/particle_force_and_move.sv
// Pair force accumulator and particle mover. Each input beat carries a focus particle and one
// neighbor; the repulsive force of that neighbor is added into saturating Q24 accumulators
// (tuser clears them first). The beat with tlast also integrates velocity and position,
// bounces off the walls at 0 and arena_size, and presents one result beat. The block works
// on one beat at a time and drops s_tready meanwhile. A neighbor beyond the cutoff adds no
// force; one inside it runs a 32-step square root and three 64-step restoring divisions
// on one shared divider plus 32x32 multiplies on one shared multiplier. A tlast beat then
// also runs the move. The next beat is accepted while a result still waits on m_tready.
module particle_force_and_move #(
    parameter int FRAC_BITS = pfm_pkg::FRAC_BITS_DEF
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_tvalid,
    output logic                               s_tready,
    // focus_x, focus_y, focus_vx, focus_vy, neighbor_x, neighbor_y
    input  logic [pfm_pkg::S_TDATA_W-1:0]      s_tdata,
    // first_neighbor
    input  logic                               s_tuser,
    input  logic                               s_tlast,
    output logic                               m_tvalid,
    input  logic                               m_tready,
    // new_x, new_y, new_vx, new_vy, total_accel_x, total_accel_y
    output logic [pfm_pkg::M_TDATA_W-1:0]      m_tdata,
    input  logic                               cfg_we,
    input  logic [pfm_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pfm_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    typedef enum logic [4:0] {
        ST_IDLE, ST_MUL, ST_DIV, ST_SQX, ST_SQY, ST_CUT, ST_MINR, ST_SQRT, ST_T1L, ST_T1,
        ST_PA, ST_PB, ST_PC, ST_MA, ST_MB, ST_REFL, ST_FIN
    } state_t;

    localparam logic signed [63:0] I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] I64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic signed [39:0] V_MAX   = 40'sh7F_FFFF_FFFF;
    localparam logic signed [39:0] V_MIN   = 40'sh80_0000_0000;
    localparam logic [95:0] DV_LIM = 96'h1 << 40;
    localparam logic [95:0] DP_LIM = 96'h1 << 60;

    state_t state_reg, ret_reg;

    logic [30:0] cutoff_reg, minr_reg, dt_reg, size_reg;
    logic [31:0] imass_reg;

    logic [30:0] fx_reg, fy_reg;
    logic signed [39:0] vx_reg, vy_reg;
    logic signed [31:0] dx_reg, dy_reg;
    logic last_reg;
    logic signed [63:0] acc_x_reg, acc_y_reg;
    logic [63:0] r2_reg, sq_v_reg, sq_res_reg, sq_bit_reg, t1_reg;
    logic [31:0] r_reg;
    logic below_reg, axis_reg, refl_reg, mul_hi_reg;
    logic [63:0] mul_a_reg;
    logic [31:0] mul_b_reg;
    logic [95:0] prod_reg;
    logic signed [39:0] v_reg;
    logic signed [63:0] p_reg;
    logic [30:0] st_x_reg, st_y_reg;
    logic signed [39:0] st_vx_reg, st_vy_reg;
    logic m_valid_reg;
    logic [30:0] ox_reg, oy_reg;
    logic signed [39:0] ovx_reg, ovy_reg;
    logic signed [63:0] oax_reg, oay_reg;

    function automatic logic signed [39:0] negv(input logic signed [39:0] v);
        return (v == V_MIN) ? V_MAX : -v;
    endfunction

    function automatic logic [63:0] abs_acc(input logic signed [63:0] a);
        logic signed [63:0] c;
        c = (a == I64_MIN) ? I64_MAX : a;
        return c[63] ? 64'(-c) : 64'(c);
    endfunction

    // input beat fields
    logic [30:0] in_fx, in_fy, in_nx, in_ny;
    logic signed [31:0] in_dx, in_dy;
    logic [31:0] in_abs_dx;
    logic in_fire;

    assign in_fx   = s_tdata[30:0];
    assign in_fy   = s_tdata[61:31];
    assign in_nx   = s_tdata[172:142];
    assign in_ny   = s_tdata[203:173];
    assign in_dx   = $signed({1'b0, in_nx}) - $signed({1'b0, in_fx});
    assign in_dy   = $signed({1'b0, in_ny}) - $signed({1'b0, in_fy});
    assign in_abs_dx = in_dx[31] ? 32'(-in_dx) : 32'(in_dx);
    assign s_tready = (state_reg == ST_IDLE);
    assign in_fire  = s_tvalid && s_tready;

    logic [31:0] abs_dx, abs_dy, abs_d;
    logic signed [31:0] cur_d;
    assign abs_dx = dx_reg[31] ? 32'(-dx_reg) : 32'(dx_reg);
    assign abs_dy = dy_reg[31] ? 32'(-dy_reg) : 32'(dy_reg);
    assign cur_d  = axis_reg ? dy_reg : dx_reg;
    assign abs_d  = axis_reg ? abs_dy : abs_dx;

    logic [30:0] mr;
    assign mr = (minr_reg == '0) ? 31'd1 : minr_reg;

    // shared multiplier, one 32x32 partial product per cycle
    logic [63:0] part;
    assign part = (mul_hi_reg ? mul_a_reg[63:32] : mul_a_reg[31:0]) * mul_b_reg;

    // square root step
    logic [63:0] sq_sum, sq_res_nx;
    logic sq_ge;
    assign sq_sum    = sq_res_reg + sq_bit_reg;
    assign sq_ge     = sq_v_reg >= sq_sum;
    assign sq_res_nx = sq_ge ? (sq_res_reg >> 1) + sq_bit_reg : sq_res_reg >> 1;

    logic [63:0] r2_max;
    assign r2_max = (r2_reg < prod_reg[63:0]) ? prod_reg[63:0] : r2_reg;

    logic t1l_below;
    logic [31:0] diff;
    assign t1l_below = r_reg < {1'b0, cutoff_reg};
    assign diff = t1l_below ? {1'b0, cutoff_reg} - r_reg : r_reg - {1'b0, cutoff_reg};

    // shared divider
    logic div_start, div_done;
    logic [pfm_pkg::DVD_W-1:0] div_dvd;
    logic [pfm_pkg::DVS_W-1:0] div_dvs, div_quot;
    assign div_start = (state_reg == ST_T1L) || (state_reg == ST_PA);
    assign div_dvd = (state_reg == ST_T1L) ? {64'b0, ({32'b0, diff} << FRAC_BITS)}
                                           : ({32'b0, prod_reg} << FRAC_BITS);
    assign div_dvs = (state_reg == ST_T1L) ? {32'b0, r_reg} : r2_reg;

    pfm_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvs),
        .done     (div_done),
        .quotient (div_quot)
    );

    logic [63:0] t2;
    assign t2 = div_quot[63] ? 64'(I64_MAX) : div_quot;

    // force term and saturating accumulate
    logic signed [63:0] m_mag, incr, acc_cur, acc_new;
    logic signed [64:0] acc_sum;
    logic f_neg;
    assign m_mag   = (|prod_reg[95:79]) ? I64_MAX : $signed({1'b0, prod_reg[78:16]});
    assign f_neg   = below_reg != cur_d[31];
    assign incr    = f_neg ? -m_mag : m_mag;
    assign acc_cur = axis_reg ? acc_y_reg : acc_x_reg;
    assign acc_sum = {acc_cur[63], acc_cur} + {incr[63], incr};
    assign acc_new = (acc_sum[64] != acc_sum[63]) ? (acc_sum[64] ? I64_MIN : I64_MAX)
                                                  : acc_sum[63:0];

    // move
    logic [95:0] prod_shf;
    logic [40:0] dv;
    logic [60:0] dp;
    logic signed [39:0] vel_cur, v_new;
    logic signed [41:0] v_sum;
    logic [39:0] abs_v_new;
    logic [30:0] pos_cur;
    logic signed [63:0] p_new;
    assign prod_shf = prod_reg >> FRAC_BITS;
    assign dv       = (prod_shf > DV_LIM) ? 41'(DV_LIM) : prod_shf[40:0];
    assign vel_cur  = axis_reg ? vy_reg : vx_reg;
    assign v_sum    = acc_cur[63] ? 42'(vel_cur) - $signed({1'b0, dv})
                                  : 42'(vel_cur) + $signed({1'b0, dv});
    assign v_new    = (v_sum > 42'(V_MAX)) ? V_MAX
                    : (v_sum < 42'(V_MIN)) ? V_MIN : v_sum[39:0];
    assign abs_v_new = v_new[39] ? 40'(-42'(v_new)) : 40'(v_new);
    assign dp       = (prod_shf > DP_LIM) ? 61'(DP_LIM) : prod_shf[60:0];
    assign pos_cur  = axis_reg ? fy_reg : fx_reg;
    assign p_new    = v_reg[39] ? $signed({33'b0, pos_cur}) - $signed({3'b0, dp})
                                : $signed({33'b0, pos_cur}) + $signed({3'b0, dp});

    // wall bounce, one reflection per cycle
    logic signed [63:0] size64, p_ref, p_cl;
    logic signed [39:0] v_ref;
    assign size64 = $signed({33'b0, size_reg});
    always_comb begin
        p_ref = p_reg;
        v_ref = v_reg;
        if (p_reg < 0) begin
            p_ref = -p_reg;
            v_ref = negv(v_reg);
        end else if (p_reg > size64) begin
            p_ref = (size64 <<< 1) - p_reg;
            v_ref = negv(v_reg);
        end
        p_cl = (p_ref < 0) ? 64'sd0 : (p_ref > size64) ? size64 : p_ref;
    end

    logic out_free;
    assign out_free = !m_valid_reg || m_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            ret_reg     <= ST_IDLE;
            cutoff_reg  <= pfm_pkg::CUTOFF_RST;
            minr_reg    <= pfm_pkg::MINR_RST;
            imass_reg   <= pfm_pkg::IMASS_RST;
            dt_reg      <= pfm_pkg::DT_RST;
            size_reg    <= pfm_pkg::SIZE_RST;
            acc_x_reg   <= '0;
            acc_y_reg   <= '0;
            m_valid_reg <= 1'b0;
            mul_hi_reg  <= 1'b0;
            axis_reg    <= 1'b0;
            refl_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_index)
                    pfm_pkg::REG_CUTOFF: cutoff_reg <= cfg_wdata[30:0];
                    pfm_pkg::REG_MINR:   minr_reg   <= cfg_wdata[30:0];
                    pfm_pkg::REG_IMASS:  imass_reg  <= cfg_wdata;
                    pfm_pkg::REG_DT:     dt_reg     <= cfg_wdata[30:0];
                    pfm_pkg::REG_SIZE:   size_reg   <= cfg_wdata[30:0];
                    default: ;
                endcase
            end

            if ((state_reg == ST_FIN) && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_fire) begin
                        fx_reg   <= in_fx;
                        fy_reg   <= in_fy;
                        vx_reg   <= s_tdata[101:62];
                        vy_reg   <= s_tdata[141:102];
                        dx_reg   <= in_dx;
                        dy_reg   <= in_dy;
                        last_reg <= s_tlast;
                        if (s_tuser) begin
                            acc_x_reg <= '0;
                            acc_y_reg <= '0;
                        end
                        mul_a_reg  <= {32'b0, in_abs_dx};
                        mul_b_reg  <= in_abs_dx;
                        mul_hi_reg <= 1'b0;
                        ret_reg    <= ST_SQX;
                        state_reg  <= ST_MUL;
                    end
                end
                ST_MUL: begin
                    if (!mul_hi_reg) begin
                        prod_reg   <= {32'b0, part};
                        mul_hi_reg <= 1'b1;
                    end else begin
                        prod_reg   <= prod_reg + {part, 32'b0};
                        mul_hi_reg <= 1'b0;
                        state_reg  <= ret_reg;
                    end
                end
                ST_DIV: begin
                    if (div_done) begin
                        state_reg <= ret_reg;
                    end
                end
                ST_SQX: begin
                    r2_reg    <= prod_reg[63:0];
                    mul_a_reg <= {32'b0, abs_dy};
                    mul_b_reg <= abs_dy;
                    ret_reg   <= ST_SQY;
                    state_reg <= ST_MUL;
                end
                ST_SQY: begin
                    r2_reg    <= r2_reg + prod_reg[63:0];
                    mul_a_reg <= {33'b0, cutoff_reg};
                    mul_b_reg <= {1'b0, cutoff_reg};
                    ret_reg   <= ST_CUT;
                    state_reg <= ST_MUL;
                end
                ST_CUT: begin
                    if (r2_reg > prod_reg[63:0]) begin
                        // out of range: no force
                        if (last_reg) begin
                            axis_reg  <= 1'b0;
                            mul_a_reg <= abs_acc(acc_x_reg);
                            mul_b_reg <= {1'b0, dt_reg};
                            ret_reg   <= ST_MA;
                            state_reg <= ST_MUL;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end else begin
                        mul_a_reg <= {33'b0, mr};
                        mul_b_reg <= {1'b0, mr};
                        ret_reg   <= ST_MINR;
                        state_reg <= ST_MUL;
                    end
                end
                ST_MINR: begin
                    r2_reg     <= r2_max;
                    sq_v_reg   <= r2_max;
                    sq_res_reg <= '0;
                    sq_bit_reg <= 64'h1 << 62;
                    state_reg  <= ST_SQRT;
                end
                ST_SQRT: begin
                    if (sq_ge) begin
                        sq_v_reg <= sq_v_reg - sq_sum;
                    end
                    sq_res_reg <= sq_res_nx;
                    sq_bit_reg <= sq_bit_reg >> 2;
                    if (sq_bit_reg[0]) begin
                        r_reg     <= sq_res_nx[31:0];
                        state_reg <= ST_T1L;
                    end
                end
                ST_T1L: begin
                    below_reg <= t1l_below;
                    ret_reg   <= ST_T1;
                    state_reg <= ST_DIV;
                end
                ST_T1: begin
                    t1_reg    <= div_quot;
                    axis_reg  <= 1'b0;
                    mul_a_reg <= div_quot;
                    mul_b_reg <= abs_dx;
                    ret_reg   <= ST_PA;
                    state_reg <= ST_MUL;
                end
                ST_PA: begin
                    ret_reg   <= ST_PB;
                    state_reg <= ST_DIV;
                end
                ST_PB: begin
                    mul_a_reg <= t2;
                    mul_b_reg <= imass_reg;
                    ret_reg   <= ST_PC;
                    state_reg <= ST_MUL;
                end
                ST_PC: begin
                    if (!axis_reg) begin
                        acc_x_reg <= acc_new;
                        axis_reg  <= 1'b1;
                        mul_a_reg <= t1_reg;
                        mul_b_reg <= abs_dy;
                        ret_reg   <= ST_PA;
                        state_reg <= ST_MUL;
                    end else begin
                        acc_y_reg <= acc_new;
                        if (last_reg) begin
                            axis_reg  <= 1'b0;
                            mul_a_reg <= abs_acc(acc_x_reg);
                            mul_b_reg <= {1'b0, dt_reg};
                            ret_reg   <= ST_MA;
                            state_reg <= ST_MUL;
                        end else begin
                            state_reg <= ST_IDLE;
                        end
                    end
                end
                ST_MA: begin
                    v_reg     <= v_new;
                    mul_a_reg <= {24'b0, abs_v_new};
                    mul_b_reg <= {1'b0, dt_reg};
                    ret_reg   <= ST_MB;
                    state_reg <= ST_MUL;
                end
                ST_MB: begin
                    p_reg     <= p_new;
                    refl_reg  <= 1'b0;
                    state_reg <= ST_REFL;
                end
                ST_REFL: begin
                    p_reg    <= p_ref;
                    v_reg    <= v_ref;
                    refl_reg <= 1'b1;
                    if (refl_reg) begin
                        if (!axis_reg) begin
                            st_x_reg  <= p_cl[30:0];
                            st_vx_reg <= v_ref;
                            axis_reg  <= 1'b1;
                            mul_a_reg <= abs_acc(acc_y_reg);
                            mul_b_reg <= {1'b0, dt_reg};
                            ret_reg   <= ST_MA;
                            state_reg <= ST_MUL;
                        end else begin
                            st_y_reg  <= p_cl[30:0];
                            st_vy_reg <= v_ref;
                            state_reg <= ST_FIN;
                        end
                    end
                end
                ST_FIN: begin
                    if (out_free) begin
                        ox_reg      <= st_x_reg;
                        oy_reg      <= st_y_reg;
                        ovx_reg     <= st_vx_reg;
                        ovy_reg     <= st_vy_reg;
                        oax_reg     <= acc_x_reg;
                        oay_reg     <= acc_y_reg;
                        state_reg   <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b0, oay_reg, oax_reg, ovy_reg, ovx_reg, oy_reg, ox_reg};

`ifndef ASSERT_OFF
    a_accept_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire |=> (state_reg == ST_MUL) && (ret_reg == ST_SQX))
        else $error("accepted beat did not start the distance multiply");

    a_first_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        in_fire && s_tuser |=> (acc_x_reg == '0) && (acc_y_reg == '0))
        else $error("first neighbor did not clear accumulators");

    a_fin_presents: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FIN) && out_free |=> m_valid_reg)
        else $error("finished move was not presented");
`endif

endmodule
